FILE: hdl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg - shared types and constants of the one-wire bus master
// Command codes, timing register indexes and reset values, and the result
// record that passes from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package owbm_pkg;

  localparam int unsigned TickW   = 10;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = $clog2(NumRegs);

  typedef logic [TickW-1:0] tick_t;
  typedef tick_t [NumRegs-1:0] tick_regs_t;

  // Commands carried on tuser
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // Timing register indexes
  typedef enum logic [RegIdxW-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_TAIL    = 3'd2,
    REG_START_PULSE   = 3'd3,
    REG_READ_SAMPLE   = 3'd4,
    REG_READ_RECOVERY = 3'd5,
    REG_WRITE_SLOT    = 3'd6,
    REG_BYTE_GAP      = 3'd7
  } reg_idx_t;

  localparam tick_regs_t RegDefaults = '{
    tick_t'(119), tick_t'(59), tick_t'(19), tick_t'(14),
    tick_t'(1),   tick_t'(229), tick_t'(69), tick_t'(479)
  };

  // One result item
  typedef struct packed {
    logic       refused;
    logic [7:0] read_byte;
    logic       presence_seen;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } res_t;

endpackage

FILE: hdl/one_wire_bus_master_core.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_core - one-wire bus master, standard speed
// Tick-timed reset, write-byte and read-byte sequencing with programmable
// slot timing over an APB-style register port.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in_     | slave     | in_tvalid / in_tready  | tuser command, tdata byte+level
//  out_    | master    | out_tvalid / out_tready| tdata result flags and byte
//  cfg_    | APB slave | psel, penable, pready  | eight 10-bit timing registers
//
// For every item (tick or command) the sequencer updates its state and the
// result lands in the output register on the same edge.
// A new request is taken each cycle while the output register is empty or
// being drained; a stalled output holds the input off.
// Reset is synchronous, active low, and restores default timing registers.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] write_data, [8] line_level, rest 0
  input  logic [1:0]  in_tuser,   // [1:0] command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] drive_low, [1] busy_res, [2] done_res,
                                  // [3] presence_seen, [11:4] read_byte,
                                  // [12] refused, rest 0
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import owbm_pkg::*;

  tick_regs_t regs_r;
  res_t       res_nxt, res_r;
  logic       out_valid_r;
  logic       in_acc, cfg_wr;
  logic [RegIdxW-1:0] cfg_idx;

  // Handshake
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // Register port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = {{(32-TickW){1'b0}}, regs_r[cfg_idx]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= RegDefaults;
    end else if (cfg_wr) begin
      regs_r[cfg_idx] <= cfg_pwdata[TickW-1:0];
    end
  end

  // Sequencer
  owbm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (in_acc),
    .cmd        (cmd_t'(in_tuser)),
    .write_data (in_tdata[7:0]),
    .line_level (in_tdata[8]),
    .regs       (regs_r),
    .res_nxt    (res_nxt)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r.refused, res_r.read_byte, res_r.presence_seen,
                       res_r.done_res, res_r.busy_res, res_r.drive_low};

`ifndef ASSERT_OFF
  // no request is taken while a result is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && out_valid_r && !out_tready))
    else $error("input taken over stalled result");

  // a completing item leaves the bus idle and released
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2]) |-> (!out_tdata[1] && !out_tdata[0]))
    else $error("done with operation still running");

  // a refused command never completes an operation and comes while busy
  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[12]) |-> (!out_tdata[2] && out_tdata[1]))
    else $error("refused result inconsistent");

  // every accepted request yields a result on the next edge
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("result lost");
`endif

endmodule

FILE: hdl/owbm_seq.sv
// ----------------------------------------------------------------------------
// owbm_seq - bus timing sequencer
// Holds phase, tick counter, bit index and shift byte; advances by one item
// per step and presents the result of that item alongside.
// ----------------------------------------------------------------------------
module owbm_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  owbm_pkg::cmd_t      cmd,
  input  logic [7:0]          write_data,
  input  logic                line_level,
  input  owbm_pkg::tick_regs_t regs,
  output owbm_pkg::res_t      res_nxt
);
  import owbm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL, PH_WR_START,
    PH_WR_SLOT, PH_BYTE_GAP, PH_RD_START, PH_RD_WAIT, PH_RD_RECOV
  } phase_t;

  phase_t     phase_r, phase_nxt;
  tick_t      wait_r, wait_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       pres_r, pres_nxt;
  logic       drive_r, drive_nxt;
  logic [7:0] last_rd_r, last_rd_nxt;
  logic       done, refused;

  // Next state for one item
  always_comb begin
    phase_nxt   = phase_r;
    wait_nxt    = wait_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    pres_nxt    = pres_r;
    drive_nxt   = drive_r;
    last_rd_nxt = last_rd_r;
    done        = 1'b0;
    refused     = 1'b0;
    if (cmd == CMD_TICK) begin
      if (phase_r != PH_IDLE) begin
        if (wait_r > tick_t'(1)) begin
          wait_nxt = wait_r - tick_t'(1);
        end else begin
          wait_nxt = '0;
          case (phase_r)
            PH_RST_LOW: begin
              phase_nxt = PH_RST_WAIT;
              wait_nxt  = regs[REG_PRESENCE_WAIT];
              drive_nxt = 1'b0;
            end
            PH_RST_WAIT: begin
              pres_nxt  = ~line_level;
              phase_nxt = PH_RST_TAIL;
              wait_nxt  = regs[REG_RESET_TAIL];
              drive_nxt = 1'b0;
            end
            PH_WR_START: begin
              phase_nxt = PH_WR_SLOT;
              wait_nxt  = regs[REG_WRITE_SLOT];
              drive_nxt = ~shift_r[bit_r];
            end
            PH_WR_SLOT: begin
              if (bit_r == 3'd7) begin
                phase_nxt = PH_BYTE_GAP;
                wait_nxt  = regs[REG_BYTE_GAP];
                drive_nxt = 1'b0;
              end else begin
                bit_nxt   = bit_r + 3'd1;
                phase_nxt = PH_WR_START;
                wait_nxt  = regs[REG_START_PULSE];
                drive_nxt = 1'b1;
              end
            end
            PH_RD_START: begin
              phase_nxt = PH_RD_WAIT;
              wait_nxt  = regs[REG_READ_SAMPLE];
              drive_nxt = 1'b0;
            end
            PH_RD_WAIT: begin
              if (line_level) shift_nxt[bit_r] = 1'b1;
              phase_nxt = PH_RD_RECOV;
              wait_nxt  = regs[REG_READ_RECOVERY];
              drive_nxt = 1'b0;
            end
            PH_RD_RECOV: begin
              if (bit_r == 3'd7) begin
                last_rd_nxt = shift_r;
                phase_nxt   = PH_IDLE;
                drive_nxt   = 1'b0;
                bit_nxt     = '0;
                done        = 1'b1;
              end else begin
                bit_nxt   = bit_r + 3'd1;
                phase_nxt = PH_RD_START;
                wait_nxt  = regs[REG_START_PULSE];
                drive_nxt = 1'b1;
              end
            end
            PH_RST_TAIL, PH_BYTE_GAP: begin
              phase_nxt = PH_IDLE;
              drive_nxt = 1'b0;
              bit_nxt   = '0;
              done      = 1'b1;
            end
            default: begin
              phase_nxt = PH_IDLE;
              drive_nxt = 1'b0;
            end
          endcase
        end
      end
    end else if (phase_r != PH_IDLE) begin
      // command while an operation runs: ignored, no time passes
      refused = 1'b1;
    end else begin
      bit_nxt   = '0;
      drive_nxt = 1'b1;
      case (cmd)
        CMD_RESET: begin
          phase_nxt = PH_RST_LOW;
          wait_nxt  = regs[REG_RESET_LOW];
        end
        CMD_WRITE: begin
          shift_nxt = write_data;
          phase_nxt = PH_WR_START;
          wait_nxt  = regs[REG_START_PULSE];
        end
        default: begin
          shift_nxt = '0;
          phase_nxt = PH_RD_START;
          wait_nxt  = regs[REG_START_PULSE];
        end
      endcase
    end
  end

  // Result of this item, after its update
  always_comb begin
    res_nxt.drive_low     = drive_nxt;
    res_nxt.busy_res      = (phase_nxt != PH_IDLE);
    res_nxt.done_res      = done;
    res_nxt.presence_seen = pres_nxt;
    res_nxt.read_byte     = last_rd_nxt;
    res_nxt.refused       = refused;
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      wait_r    <= '0;
      bit_r     <= '0;
      shift_r   <= '0;
      pres_r    <= 1'b0;
      drive_r   <= 1'b0;
      last_rd_r <= '0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      wait_r    <= wait_nxt;
      bit_r     <= bit_nxt;
      shift_r   <= shift_nxt;
      pres_r    <= pres_nxt;
      drive_r   <= drive_nxt;
      last_rd_r <= last_rd_nxt;
    end
  end

endmodule

FILE: dv/owbm_result_checker.sv
// ----------------------------------------------------------------------------
// owbm_result_checker - result predictor and scoreboard for the bus master
// Watches the request, result and register ports, keeps its own copy of
// the sequencer state and timing registers, and compares every result
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module owbm_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] write_data, [8] line_level, rest 0
  input  logic [1:0]  in_tuser,   // [1:0] command
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [0] drive_low, [1] busy_res, [2] done_res,
                                  // [3] presence_seen, [11:4] read_byte,
                                  // [12] refused, rest 0
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int unsigned errors,
  output int unsigned pending,
  output logic        seq_busy
);
  import owbm_pkg::*;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_RST_LOW,
    SQ_RST_WAIT,
    SQ_RST_TAIL,
    SQ_WR_START,
    SQ_WR_SLOT,
    SQ_BYTE_GAP,
    SQ_RD_START,
    SQ_RD_WAIT,
    SQ_RD_RECOV
  } seq_phase_t;

  // Shadow of the sequencer
  seq_phase_t  phase_q;
  tick_t       count_q;
  logic [2:0]  bit_q;
  logic [7:0]  shift_q;
  logic        presence_q;
  logic        drive_q;
  logic [7:0]  last_read_q;
  tick_regs_t  timing;

  res_t        expected_results [$];
  int unsigned err_count = 0;

  assign errors = err_count;

  task automatic clear_shadow();
    timing[REG_RESET_LOW]     = tick_t'(479);
    timing[REG_PRESENCE_WAIT] = tick_t'(69);
    timing[REG_RESET_TAIL]    = tick_t'(229);
    timing[REG_START_PULSE]   = tick_t'(1);
    timing[REG_READ_SAMPLE]   = tick_t'(14);
    timing[REG_READ_RECOVERY] = tick_t'(19);
    timing[REG_WRITE_SLOT]    = tick_t'(59);
    timing[REG_BYTE_GAP]      = tick_t'(119);
    phase_q     = SQ_IDLE;
    count_q     = '0;
    bit_q       = '0;
    shift_q     = '0;
    presence_q  = 1'b0;
    drive_q     = 1'b0;
    last_read_q = '0;
  endtask

  task automatic enter_phase(input seq_phase_t ph, input reg_idx_t idx, input logic drive);
    phase_q = ph;
    count_q = timing[idx];
    drive_q = drive;
  endtask

  // One microsecond passes: count down, or move to the next phase
  task automatic advance_tick(input logic level, output logic completed);
    logic finish;
    completed = 1'b0;
    finish    = 1'b0;
    if (phase_q != SQ_IDLE) begin
      if (count_q > tick_t'(1)) begin
        count_q = count_q - tick_t'(1);
      end else begin
        count_q = '0;
        case (phase_q)
          SQ_RST_LOW: begin
            enter_phase(SQ_RST_WAIT, REG_PRESENCE_WAIT, 1'b0);
          end
          SQ_RST_WAIT: begin
            // a device answers by holding the line low
            presence_q = ~level;
            enter_phase(SQ_RST_TAIL, REG_RESET_TAIL, 1'b0);
          end
          SQ_RST_TAIL: begin
            finish = 1'b1;
          end
          SQ_WR_START: begin
            // a zero keeps the line low for the slot, a one releases it
            enter_phase(SQ_WR_SLOT, REG_WRITE_SLOT, ~shift_q[bit_q]);
          end
          SQ_WR_SLOT: begin
            if (bit_q == 3'd7) begin
              enter_phase(SQ_BYTE_GAP, REG_BYTE_GAP, 1'b0);
            end else begin
              bit_q = bit_q + 3'd1;
              enter_phase(SQ_WR_START, REG_START_PULSE, 1'b1);
            end
          end
          SQ_BYTE_GAP: begin
            finish = 1'b1;
          end
          SQ_RD_START: begin
            enter_phase(SQ_RD_WAIT, REG_READ_SAMPLE, 1'b0);
          end
          SQ_RD_WAIT: begin
            if (level) shift_q[bit_q] = 1'b1;
            enter_phase(SQ_RD_RECOV, REG_READ_RECOVERY, 1'b0);
          end
          SQ_RD_RECOV: begin
            if (bit_q == 3'd7) begin
              last_read_q = shift_q;
              finish      = 1'b1;
            end else begin
              bit_q = bit_q + 3'd1;
              enter_phase(SQ_RD_START, REG_START_PULSE, 1'b1);
            end
          end
          default: begin
            phase_q = SQ_IDLE;
            drive_q = 1'b0;
          end
        endcase
        if (finish) begin
          phase_q   = SQ_IDLE;
          drive_q   = 1'b0;
          bit_q     = '0;
          completed = 1'b1;
        end
      end
    end
  endtask

  // Work out the result of one accepted request
  task automatic predict_request(input cmd_t cmd, input logic [7:0] data,
                                 input logic level, output res_t r);
    logic completed;
    logic turned_away;
    completed   = 1'b0;
    turned_away = 1'b0;
    if (cmd == CMD_TICK) begin
      advance_tick(level, completed);
    end else if (phase_q != SQ_IDLE) begin
      turned_away = 1'b1;
    end else begin
      bit_q = '0;
      case (cmd)
        CMD_RESET: begin
          enter_phase(SQ_RST_LOW, REG_RESET_LOW, 1'b1);
        end
        CMD_WRITE: begin
          shift_q = data;
          enter_phase(SQ_WR_START, REG_START_PULSE, 1'b1);
        end
        default: begin
          shift_q = '0;
          enter_phase(SQ_RD_START, REG_START_PULSE, 1'b1);
        end
      endcase
    end
    r.drive_low     = drive_q;
    r.busy_res      = (phase_q != SQ_IDLE);
    r.done_res      = completed;
    r.presence_seen = presence_q;
    r.read_byte     = last_read_q;
    r.refused       = turned_away;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      clear_shadow();
      expected_results.delete();
    end else begin
      // result side first: it can only carry a result predicted earlier
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[12:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: result %h with none expected, expected nothing, actual %h",
                   $time, out_tdata, out_tdata);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("drive_low", 32'(want.drive_low), 32'(got.drive_low));
          check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
          check_field("done_res", 32'(want.done_res), 32'(got.done_res));
          check_field("presence_seen", 32'(want.presence_seen), 32'(got.presence_seen));
          check_field("read_byte", 32'(want.read_byte), 32'(got.read_byte));
          check_field("refused", 32'(want.refused), 32'(got.refused));
          check_field("tdata padding", 0, 32'(out_tdata[15:13]));
        end
      end
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        timing[cfg_paddr[4:2]] = cfg_pwdata[TickW-1:0];
      end
      // requests
      if (in_tvalid && in_tready) begin
        predict_request(cmd_t'(in_tuser), in_tdata[7:0], in_tdata[8], want);
        expected_results.push_back(want);
      end
    end
    pending  <= expected_results.size();
    seq_busy <= (phase_q != SQ_IDLE);
  end

endmodule

FILE: dv/one_wire_bus_master_core_tb.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_core_tb - stimulus and verdict for the bus master
// Drives tick and command requests with random gaps and result stalls,
// programs the timing registers between phases, and leaves prediction and
// comparison to the result checker.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core_tb;
  import owbm_pkg::*;

  localparam int StallLimit = 4000;
  localparam int RandomOps  = 850;
  localparam int HoldCycles = 300;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;   // [7:0] write_data, [8] line_level, rest 0
  logic [1:0]  in_tuser    = '0;   // [1:0] command
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;          // [0] drive_low, [1] busy_res, [2] done_res,
                                   // [3] presence_seen, [11:4] read_byte,
                                   // [12] refused, rest 0
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [4:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int unsigned errors;
  int unsigned pending;
  logic        seq_busy;

  // idling percentages and progress, shared with the receiver process
  int          tx_idle_pct = 19;
  int          rx_idle_pct = 77;
  int unsigned op_items    = 0;
  bit          in_random   = 1'b0;
  bit          hold_done   = 1'b0;
  int unsigned quiet_cycles = 0;

  tick_t       timing_now [NumRegs];

  one_wire_bus_master_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  owbm_result_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .errors      (errors),
    .pending     (pending),
    .seq_busy    (seq_busy)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off once random traffic runs
  initial begin
    forever begin
      @(posedge clk);
      if (in_random && !hold_done && op_items >= 200) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HoldCycles - 1) begin
          @(posedge clk);
          out_tready <= 1'b0;
        end
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no transfer on any port
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("** one_wire_bus_master_core: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Length of a phase: zero counts as one tick
  function automatic int unsigned slot_len(input reg_idx_t idx);
    return (timing_now[idx] == '0) ? 1 : int'(timing_now[idx]);
  endfunction

  function automatic int unsigned op_ticks(input cmd_t cmd);
    case (cmd)
      CMD_RESET: return slot_len(REG_RESET_LOW) + slot_len(REG_PRESENCE_WAIT) +
                        slot_len(REG_RESET_TAIL);
      CMD_WRITE: return 8 * (slot_len(REG_START_PULSE) + slot_len(REG_WRITE_SLOT)) +
                        slot_len(REG_BYTE_GAP);
      CMD_READ:  return 8 * (slot_len(REG_START_PULSE) + slot_len(REG_READ_SAMPLE) +
                             slot_len(REG_READ_RECOVERY));
      default:   return 0;
    endcase
  endfunction

  // 0 low, 1 high, anything else random
  function automatic logic pick_level(input int sel);
    if (sel == 0) return 1'b0;
    if (sel == 1) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  // Mostly short phases; the full range only on phases used once per command
  function automatic tick_t rand_tick(input reg_idx_t idx);
    int    roll;
    tick_t v;
    logic  once;
    once = (idx == REG_RESET_LOW) || (idx == REG_PRESENCE_WAIT) ||
           (idx == REG_RESET_TAIL) || (idx == REG_BYTE_GAP);
    roll = $urandom_range(0, 99);
    if (roll < 75)                v = tick_t'($urandom_range(0, 3));
    else if (roll < 99 || !once)  v = tick_t'($urandom_range(0, 9));
    else                          v = tick_t'($urandom_range(0, 1023));
    if (idx == REG_START_PULSE && v == '0) v = tick_t'(1);
    return v;
  endfunction

  // Offer one request and wait for it to be taken
  task automatic send_request(input cmd_t cmd, input logic [7:0] data, input logic level);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, level, data};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Wait until every result is back and the sequencer has gone idle
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || seq_busy) begin
      if (pending == 0) begin
        send_request(CMD_TICK, 8'($urandom), pick_level(2));
        in_tvalid <= 1'b0;
      end
      @(posedge clk);
    end
  endtask

  // Program all timing registers back to back, then drop the bus
  task automatic set_all_timing(input tick_t vals [NumRegs]);
    for (int i = 0; i < NumRegs; i++) begin
      cfg_psel    <= 1'b1;
      cfg_pwrite  <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_paddr   <= 5'(i * 4);
      cfg_pwdata  <= 32'(vals[i]);
      @(posedge clk);
      cfg_penable <= 1'b1;
      @(posedge clk);
      while (!cfg_pready) @(posedge clk);
      timing_now[i] = vals[i];
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Ticks, with the odd refused command mixed in when noisy
  task automatic tick_run(input int unsigned n, input int level_sel, input bit noisy);
    repeat (n) begin
      if (noisy && $urandom_range(0, 15) == 0) begin
        send_request(cmd_t'($urandom_range(1, 3)), 8'($urandom), pick_level(2));
      end
      send_request(CMD_TICK, 8'($urandom), pick_level(level_sel));
      op_items++;
    end
  endtask

  // One command and the ticks it needs; noisy runs sometimes cut it short
  task automatic run_op(input cmd_t cmd, input logic [7:0] data, input int level_sel,
                        input bit noisy);
    int unsigned n;
    send_request(cmd, data, pick_level(2));
    op_items++;
    n = op_ticks(cmd);
    if (noisy && $urandom_range(0, 7) == 0) n = $urandom_range(0, n - 1);
    tick_run(n, level_sel, noisy);
  endtask

  initial begin
    tick_t set_vals [NumRegs];
    cmd_t  cmd;
    int    n_ops;

    for (int i = 0; i < NumRegs; i++) timing_now[i] = RegDefaults[i];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default timing: idle ticks, a read, busy refusals
    tick_run(2, 2, 1'b0);
    send_request(CMD_READ, 8'h00, 1'b1);
    send_request(CMD_RESET, 8'hFF, 1'b0);
    send_request(CMD_WRITE, 8'h3C, 1'b1);
    send_request(CMD_READ, 8'h81, 1'b0);
    tick_run(op_ticks(CMD_READ), 2, 1'b0);
    settle();

    // Zero-length phases: byte extremes, all-low read, no presence
    for (int i = 0; i < NumRegs; i++) set_vals[i] = '0;
    set_vals[REG_START_PULSE] = tick_t'(1);
    set_all_timing(set_vals);
    run_op(CMD_WRITE, 8'h00, 2, 1'b0);
    run_op(CMD_WRITE, 8'hFF, 2, 1'b0);
    run_op(CMD_READ, 8'hA5, 0, 1'b0);
    run_op(CMD_RESET, 8'h00, 1, 1'b0);
    // partial read: a command refused in the middle, old byte held meanwhile
    send_request(CMD_READ, 8'h00, 1'b1);
    tick_run(5, 2, 1'b0);
    send_request(CMD_WRITE, 8'hC3, 1'b0);
    tick_run(op_ticks(CMD_READ) - 5, 2, 1'b0);
    settle();

    // Random phases of well-formed operations with some noise
    in_random = 1'b1;
    op_items  = 0;
    while (op_items < RandomOps) begin
      if (op_items < RandomOps / 3) begin
        tx_idle_pct = 19;
        rx_idle_pct = 77;
      end else if (op_items < 2 * RandomOps / 3) begin
        tx_idle_pct = 77;
        rx_idle_pct = 19;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      settle();
      for (int i = 0; i < NumRegs; i++) set_vals[i] = rand_tick(reg_idx_t'(i));
      set_all_timing(set_vals);
      n_ops = $urandom_range(2, 6);
      repeat (n_ops) begin
        cmd = cmd_t'($urandom_range(1, 3));
        run_op(cmd, 8'($urandom), 2, 1'b1);
        if ($urandom_range(0, 3) == 0) begin
          send_request(CMD_TICK, 8'($urandom), pick_level(2));
        end
      end
    end

    // Drain and give the verdict
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("** one_wire_bus_master_core: PASSED **");
    end else begin
      $display("** one_wire_bus_master_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: one_wire_bus_master_core.f
hdl/owbm_pkg.sv
hdl/owbm_seq.sv
hdl/one_wire_bus_master_core.sv
dv/owbm_result_checker.sv
dv/one_wire_bus_master_core_tb.sv
